[src/dab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dab_pkg;

  typedef struct packed {
    logic [15:0] reply_flags;
    logic [15:0] name_pointer;
    logic [31:0] time_to_live;
    logic [31:0] answer_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       truncated;
  } res_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_FLAGS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_POINTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 2'd3;

  localparam logic [15:0] RST_REPLY_FLAGS    = 16'd33152;
  localparam logic [15:0] RST_NAME_POINTER   = 16'd49164;
  localparam logic [31:0] RST_TIME_TO_LIVE   = 32'd600;
  localparam logic [31:0] RST_ANSWER_ADDRESS = 32'd0;

  // header byte offsets
  localparam logic [3:0] HDR_ID_HI      = 4'd0;
  localparam logic [3:0] HDR_ID_LO      = 4'd1;
  localparam logic [3:0] HDR_FLAGS_HI   = 4'd2;
  localparam logic [3:0] HDR_FLAGS_LO   = 4'd3;
  localparam logic [3:0] HDR_QDCOUNT_HI = 4'd4;
  localparam logic [3:0] HDR_QDCOUNT_LO = 4'd5;
  localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
  localparam logic [3:0] HDR_LAST       = 4'd11;

  localparam logic [7:0] ANS_COUNT = 8'd1;
  localparam logic [7:0] ANS_RDLEN = 8'd4;
  // answer record bytes after the final class byte
  localparam logic [4:0] ANS_LEN   = 5'd16;

endpackage

`default_nettype wire

[src/dab_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface dab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       truncated;

  modport source (output valid, output out_byte, output out_last, output truncated,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input truncated,
                output ready);
endinterface

`default_nettype wire

[src/dab_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module dab_cfg
  import dab_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_flags    <= RST_REPLY_FLAGS;
      cfg_r.name_pointer   <= RST_NAME_POINTER;
      cfg_r.time_to_live   <= RST_TIME_TO_LIVE;
      cfg_r.answer_address <= RST_ANSWER_ADDRESS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPLY_FLAGS:    cfg_r.reply_flags    <= cfg_data[15:0];
        CFG_NAME_POINTER:   cfg_r.name_pointer   <= cfg_data[15:0];
        CFG_TIME_TO_LIVE:   cfg_r.time_to_live   <= cfg_data;
        CFG_ANSWER_ADDRESS: cfg_r.answer_address <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/dab_framer.sv]
`timescale 1ns / 1ps
`default_nettype none

module dab_framer
  import dab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            in_ready,
  output logic            s_valid,
  output res_t            s_res,
  input  wire logic       s_ready
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_LABEL,
    PH_TAIL,
    PH_DROP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  label_left_r, label_left_nxt;
  logic [15:0] qtype_r, qtype_nxt;
  logic [15:0] qclass_r, qclass_nxt;
  logic [4:0]  ans_cnt_r, ans_cnt_nxt;

  logic       acc;
  logic       emit;
  logic       answer;
  logic [7:0] o;
  logic [7:0] ans_byte;

  assign in_ready = (ans_cnt_r == 5'd0) && s_ready;
  assign acc = in_valid && in_ready;

  // next state for one query byte
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    label_left_nxt = label_left_r;
    qtype_nxt      = qtype_r;
    qclass_nxt     = qclass_r;
    o              = in_byte;
    emit           = 1'b1;
    answer         = 1'b0;

    case (phase_r)
      PH_DROP: begin
        emit = 1'b0;
        if (in_last) begin
          phase_nxt = PH_HEADER;
          pos_nxt   = 4'd0;
        end
      end
      PH_LEN: begin
        if (in_byte == 8'd0) begin
          phase_nxt = PH_TAIL;
          pos_nxt   = 4'd0;
        end else begin
          label_left_nxt = in_byte;
          phase_nxt      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_left_nxt = label_left_r - 8'd1;
        if (label_left_nxt == 8'd0) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_TAIL: begin
        case (pos_r[1:0])
          2'd0:    qtype_nxt  = {in_byte, qtype_r[7:0]};
          2'd1:    qtype_nxt  = {qtype_r[15:8], in_byte};
          2'd2:    qclass_nxt = {in_byte, qclass_r[7:0]};
          default: qclass_nxt = {qclass_r[15:8], in_byte};
        endcase
        if (pos_r[1:0] == 2'd3) begin
          answer    = 1'b1;
          pos_nxt   = 4'd0;
          phase_nxt = in_last ? PH_HEADER : PH_DROP;
        end else begin
          pos_nxt = {2'b00, pos_r[1:0] + 2'd1};
        end
      end
      default: begin
        case (pos_r)
          HDR_FLAGS_HI:   o = cfg.reply_flags[15:8];
          HDR_FLAGS_LO:   o = cfg.reply_flags[7:0];
          HDR_ANCOUNT_LO: o = ANS_COUNT;
          HDR_ID_HI, HDR_ID_LO, HDR_QDCOUNT_HI, HDR_QDCOUNT_LO: o = in_byte;
          default:        o = 8'd0;
        endcase
        if (pos_r >= HDR_LAST) begin
          phase_nxt = PH_LEN;
          pos_nxt   = 4'd0;
        end else begin
          phase_nxt = PH_HEADER;
          pos_nxt   = pos_r + 4'd1;
        end
      end
    endcase

    // early end of the query
    if (in_last && !answer && (phase_r != PH_DROP)) begin
      phase_nxt      = PH_HEADER;
      pos_nxt        = 4'd0;
      label_left_nxt = 8'd0;
    end
  end

  // answer record byte picked by the remaining count
  always_comb begin
    case (ans_cnt_r)
      5'd16:   ans_byte = cfg.name_pointer[15:8];
      5'd15:   ans_byte = cfg.name_pointer[7:0];
      5'd14:   ans_byte = qtype_r[15:8];
      5'd13:   ans_byte = qtype_r[7:0];
      5'd12:   ans_byte = qclass_r[15:8];
      5'd11:   ans_byte = qclass_r[7:0];
      5'd10:   ans_byte = cfg.time_to_live[31:24];
      5'd9:    ans_byte = cfg.time_to_live[23:16];
      5'd8:    ans_byte = cfg.time_to_live[15:8];
      5'd7:    ans_byte = cfg.time_to_live[7:0];
      5'd6:    ans_byte = 8'd0;
      5'd5:    ans_byte = ANS_RDLEN;
      5'd4:    ans_byte = cfg.answer_address[31:24];
      5'd3:    ans_byte = cfg.answer_address[23:16];
      5'd2:    ans_byte = cfg.answer_address[15:8];
      5'd1:    ans_byte = cfg.answer_address[7:0];
      default: ans_byte = 8'd0;
    endcase
  end

  always_comb begin
    ans_cnt_nxt = ans_cnt_r;
    if (ans_cnt_r != 5'd0) begin
      s_valid         = 1'b1;
      s_res.data      = ans_byte;
      s_res.last      = (ans_cnt_r == 5'd1);
      s_res.truncated = 1'b0;
      if (s_ready) begin
        ans_cnt_nxt = ans_cnt_r - 5'd1;
      end
    end else begin
      s_valid         = in_valid && emit;
      s_res.data      = o;
      s_res.last      = in_last && !answer;
      s_res.truncated = in_last && !answer;
      if (acc && answer) begin
        ans_cnt_nxt = ANS_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      pos_r        <= 4'd0;
      label_left_r <= 8'd0;
      qtype_r      <= 16'd0;
      qclass_r     <= 16'd0;
      ans_cnt_r    <= 5'd0;
    end else begin
      ans_cnt_r <= ans_cnt_nxt;
      if (acc) begin
        phase_r      <= phase_nxt;
        pos_r        <= pos_nxt;
        label_left_r <= label_left_nxt;
        qtype_r      <= qtype_nxt;
        qclass_r     <= qclass_nxt;
      end
    end
  end

  a_answer_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (phase_r == PH_TAIL) && (pos_r[1:0] == 2'd3)) |=> (ans_cnt_r == ANS_LEN))
    else $error("answer record not started after class byte");

  a_answer_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ans_cnt_r != 5'd0) |=>
      ((ans_cnt_r == $past(ans_cnt_r)) || (ans_cnt_r == ($past(ans_cnt_r) - 5'd1))))
    else $error("answer byte count jumped");

endmodule

`default_nettype wire

[src/dab_skid.sv]
`timescale 1ns / 1ps
`default_nettype none

module dab_skid
  import dab_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s_valid,
  input  wire res_t s_res,
  output logic      s_ready,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_ready
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;

  assign s_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_res_r    <= skid_res_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_res_r   <= s_res;
        out_valid_r <= s_valid;
      end
    end else if (s_valid && !skid_valid_r) begin
      skid_res_r   <= s_res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction ahead of the output register");

  a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s_valid && s_ready) |=> skid_valid_r)
    else $error("transaction lost while output stalled");

endmodule

`default_nettype wire

[src/dns_a_record_answer_builder_top.sv]
// DNS A-record reply builder. Query bytes go in one per cycle and reply bytes
// come out one per cycle while the output is ready and no answer record is
// being sent: the header is rewritten (flags from reply_flags, one answer, no
// authority or additional records), the name and type/class are copied, and
// the byte that completes the class is followed by a 16-byte answer record;
// query bytes after the question are dropped. Input is held off after the last
// class byte while the answer record is sent from its byte counter. A query
// that ends early gives its last reply byte with out_last and truncated set.
// The output is an output register plus a skid stage, so input is taken while
// a reply byte waits. Write the configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module dns_a_record_answer_builder_top
  import dab_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dab_in_if.sink                     in_ch,
  dab_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic s_valid;
  logic s_ready;
  res_t s_res;
  res_t out_res;

  dab_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dab_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .in_ready (in_ch.ready),
    .s_valid  (s_valid),
    .s_res    (s_res),
    .s_ready  (s_ready)
  );

  dab_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_res     (s_res),
    .s_ready   (s_ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.out_byte  = out_res.data;
  assign out_ch.out_last  = out_res.last;
  assign out_ch.truncated = out_res.truncated;

endmodule

`default_nettype wire

[sim/dns_reply_checker.sv]
`timescale 1ns / 1ps

module dns_reply_checker
  import dab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dab_in_if                     in_mon,
  dab_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    pending
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DROP   = 3'd4
  } parse_phase_t;

  cfg_t         regs;
  parse_phase_t phase;
  logic [3:0]   position;
  logic [7:0]   label_left;
  logic [15:0]  query_type;
  logic [15:0]  query_class;
  res_t         reply_q[$];
  res_t         expected;
  res_t         actual;

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic push_reply(input logic [7:0] data, input logic fin, input logic trunc);
    res_t r;
    r.data      = data;
    r.last      = fin;
    r.truncated = trunc;
    reply_q.push_back(r);
  endtask

  // works out the reply bytes caused by one query byte
  task automatic build_reply(input logic [7:0] qbyte, input logic fin);
    logic [7:0]   o;
    logic [127:0] answer;
    o = qbyte;
    if (phase == PH_DROP) begin
      if (fin) begin
        phase    = PH_HEADER;
        position = '0;
      end
      return;
    end
    case (phase)
      PH_LEN: begin
        if (qbyte == 8'd0) begin
          phase    = PH_TAIL;
          position = '0;
        end else begin
          label_left = qbyte;
          phase      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) phase = PH_LEN;
      end
      PH_TAIL: begin
        case (position[1:0])
          2'd0:    query_type[15:8]  = qbyte;
          2'd1:    query_type[7:0]   = qbyte;
          2'd2:    query_class[15:8] = qbyte;
          default: query_class[7:0]  = qbyte;
        endcase
        if (position[1:0] == 2'd3) begin
          push_reply(qbyte, 1'b0, 1'b0);
          answer = {regs.name_pointer, query_type, query_class, regs.time_to_live,
                    8'h00, ANS_RDLEN, regs.answer_address};
          for (int i = int'(ANS_LEN) - 1; i >= 0; i--)
            push_reply(answer[i*8 +: 8], i == 0, 1'b0);
          position = '0;
          phase    = fin ? PH_HEADER : PH_DROP;
          return;
        end
        position = {2'b00, position[1:0] + 2'd1};
      end
      default: begin
        case (position)
          HDR_FLAGS_HI:   o = regs.reply_flags[15:8];
          HDR_FLAGS_LO:   o = regs.reply_flags[7:0];
          HDR_ANCOUNT_LO: o = ANS_COUNT;
          HDR_ID_HI, HDR_ID_LO, HDR_QDCOUNT_HI, HDR_QDCOUNT_LO: o = qbyte;
          default:        o = 8'd0;
        endcase
        if (position >= HDR_LAST) begin
          phase    = PH_LEN;
          position = '0;
        end else begin
          phase    = PH_HEADER;
          position = position + 4'd1;
        end
      end
    endcase
    if (fin) begin
      push_reply(o, 1'b1, 1'b1);
      phase      = PH_HEADER;
      position   = '0;
      label_left = '0;
    end else begin
      push_reply(o, 1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.reply_flags    = RST_REPLY_FLAGS;
      regs.name_pointer   = RST_NAME_POINTER;
      regs.time_to_live   = RST_TIME_TO_LIVE;
      regs.answer_address = RST_ANSWER_ADDRESS;
      phase       = PH_HEADER;
      position    = '0;
      label_left  = '0;
      query_type  = '0;
      query_class = '0;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPLY_FLAGS:    regs.reply_flags    = cfg_data[15:0];
          CFG_NAME_POINTER:   regs.name_pointer   = cfg_data[15:0];
          CFG_TIME_TO_LIVE:   regs.time_to_live   = cfg_data;
          CFG_ANSWER_ADDRESS: regs.answer_address = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        build_reply(in_mon.in_byte, in_mon.in_last);
      if (out_mon.valid && out_mon.ready) begin
        actual.data      = out_mon.out_byte;
        actual.last      = out_mon.out_last;
        actual.truncated = out_mon.truncated;
        if (reply_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected reply byte, got data %h last %b truncated %b",
                   $time, actual.data, actual.last, actual.truncated);
        end else begin
          expected = reply_q.pop_front();
          if (actual !== expected) begin
            failures++;
            $display("%0t: reply mismatch, expected %h/%b/%b, got %h/%b/%b",
                     $time, expected.data, expected.last, expected.truncated,
                     actual.data, actual.last, actual.truncated);
          end
        end
      end
    end
    pending <= reply_q.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dab_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;
  int                    cycle_count = 0;
  int                    items_sent = 0;
  int                    stall_left = 0;
  logic                  idle_on = 1'b0;
  logic [7:0]            query_bytes[$];

  dab_in_if  in_ch ();
  dab_out_if out_ch ();

  dns_a_record_answer_builder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dns_reply_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // reply side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_ch.ready <= (stall_left == 0);
  end

  task automatic send_byte(input logic [7:0] qbyte, input logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= qbyte;
    in_ch.in_last <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_query();
    foreach (query_bytes[i])
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  // mostly well-formed queries, some cut short, a few plain noise
  task automatic make_query();
    int kind;
    int labels;
    int len;
    query_bytes.delete();
    kind = $urandom_range(0, 19);
    if (kind >= 18) begin
      repeat ($urandom_range(1, 16)) query_bytes.push_back(8'($urandom));
      return;
    end
    repeat (12) query_bytes.push_back(8'($urandom));
    labels = $urandom_range(0, 4);
    repeat (labels) begin
      if ($urandom_range(0, 11) == 0)
        len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(64, 80);
      else
        len = $urandom_range(1, 12);
      query_bytes.push_back(8'(len));
      repeat (len) query_bytes.push_back(8'($urandom));
    end
    query_bytes.push_back(8'h00);
    repeat (4) query_bytes.push_back(8'($urandom));
    if (kind >= 15) begin
      len = $urandom_range(1, query_bytes.size() - 1);
      while (query_bytes.size() > len) void'(query_bytes.pop_back());
    end else if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 6)) query_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_REPLY_FLAGS, {16'($urandom), c.reply_flags});
    write_reg(CFG_NAME_POINTER, {16'($urandom), c.name_pointer});
    write_reg(CFG_TIME_TO_LIVE, c.time_to_live);
    write_reg(CFG_ANSWER_ADDRESS, c.answer_address);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t c;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_REPLY_FLAGS;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // root-name query ending on its class byte, then early ends
    idle_on = 1'b1;
    query_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                    8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_query();
    query_bytes = '{8'hFF, 8'h00, 8'hFF};
    send_query();
    query_bytes = '{8'h80};
    send_query();

    for (int k = 0; k < 4; k++) begin
      drain();
      if (k == 0) c = '0;
      else if (k == 1) c = '1;
      else begin
        c.reply_flags    = 16'($urandom);
        c.name_pointer   = 16'($urandom);
        c.time_to_live   = $urandom;
        c.answer_address = $urandom;
      end
      load_config(c);
      while (items_sent < 21 + 85 * (k + 1)) begin
        idle_on = (k != 3) && ($urandom_range(0, 3) != 0);
        make_query();
        send_query();
      end
    end

    drain();
    if (failures == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
